// ===== rtl/assert_macros.svh =====
// assertion macros used by first_match_route_table_top
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/fmrt_pkg.sv =====
// types, constants and helpers of the first-match route table
// no dependencies
package fmrt_pkg;

  localparam int MAX_ROUTES = 8;
  localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W      = $clog2(MAX_ROUTES + 1);
  localparam int EXT_W      = (IDX_W > 3) ? IDX_W : 3;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_FULL  = 3'd1,
    ST_MATCH = 3'd2,
    ST_LAST  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // one route entry
  typedef struct packed {
    logic [31:0] dst;
    logic [31:0] gateway;
    logic [31:0] mask;
    logic [7:0]  flags;
    logic [31:0] metric;
    logic [3:0]  device;
  } entry_t;

  // lookup token moving along the cell row
  typedef struct packed {
    logic [31:0]      addr;
    logic             done;
    status_t          status;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } token_t;

  // one finished result
  typedef struct packed {
    status_t    status;
    logic [2:0] idx;
    entry_t     entry;
  } result_t;

  // low three bits of a slot number
  function automatic logic [2:0] idx_low3(input logic [IDX_W-1:0] idx);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(idx);
    return ext[2:0];
  endfunction

endpackage

// ===== rtl/fmrt_cell.sv =====
// one cell of the route table row: holds one entry and checks passing tokens
// depends on fmrt_pkg
module fmrt_cell
  import fmrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic             wr_en,
  input  entry_t           wr_entry,
  input  logic             active,
  input  logic             last,
  input  logic             tok_v_in,
  input  token_t           tok_in,
  output logic             tok_v_out,
  output token_t           tok_out
);

  entry_t entry_r;
  logic   tok_v_r;
  token_t tok_r;
  token_t tok_nxt;
  logic   hit;
  logic   take_last;

  // entry storage, written by an add while this cell is the next free slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  // compare against the passing address
  always_comb begin
    hit       = active && !tok_in.done && ((entry_r.mask & tok_in.addr) == entry_r.dst);
    take_last = active && !tok_in.done && !hit && last;
    tok_nxt   = tok_in;
    if (hit || take_last) begin
      tok_nxt.done   = 1'b1;
      tok_nxt.status = hit ? ST_MATCH : ST_LAST;
      tok_nxt.idx    = cell_idx;
      tok_nxt.entry  = entry_r;
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_v_out = tok_v_r;
  assign tok_out   = tok_r;

endmodule

// ===== rtl/first_match_route_table_top.sv =====
// first-match ipv4 route table: a row of MAX_ROUTES cells plus control
// add, empty and full: the result is registered, one per cycle unstalled
// lookup: the token crosses one cell per cycle through the registered cells, and the
// input stalls until the result has reached the output register: one lookup at a time
// reset (synchronous, rst_n low) empties the table; entry contents are not cleared
// depends on fmrt_pkg, fmrt_cell and assert_macros.svh
`include "assert_macros.svh"
module first_match_route_table_top
  import fmrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_dest_network_in,
  input  logic [31:0] in_gateway_in,
  input  logic [31:0] in_netmask_in,
  input  logic [7:0]  in_flags_in,
  input  logic [31:0] in_metric_in,
  input  logic [3:0]  in_device_in,
  input  logic [31:0] in_lookup_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_entry_index,
  output logic [31:0] out_dst,
  output logic [31:0] out_gateway,
  output logic [31:0] out_netmask,
  output logic [7:0]  out_flags,
  output logic [31:0] out_metric,
  output logic [3:0]  out_device
);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             pend_v_r;
  result_t          pend_r;
  logic             out_valid_r;
  result_t          out_r;

  logic    in_fire;
  logic    is_add;
  logic    full;
  logic    empty;
  logic    add_ok;
  logic    start;
  logic    res_v;
  result_t res;
  logic    out_free;
  entry_t  new_entry;

  logic   tok_v [0:MAX_ROUTES];
  token_t tok   [0:MAX_ROUTES];

  // input decode
  assign in_stall  = busy_r;
  assign in_fire   = in_valid && !in_stall;
  assign is_add    = (cmd_t'(in_command) == CMD_ADD);
  assign full      = (cnt_r == CNT_W'(MAX_ROUTES));
  assign empty     = (cnt_r == '0);
  assign add_ok    = in_fire && is_add && !full;
  assign start     = in_fire && !is_add && !empty;
  assign out_free  = !out_valid_r || !out_stall;

  assign new_entry = '{dst:     in_dest_network_in,
                       gateway: in_gateway_in,
                       mask:    in_netmask_in,
                       flags:   in_flags_in,
                       metric:  in_metric_in,
                       device:  in_device_in};

  // token entering the first cell
  assign tok_v[0] = start;
  assign tok[0]   = '{addr: in_lookup_address, done: 1'b0, status: ST_MATCH,
                      idx: '0, entry: '0};

  // row of cells
  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
    fmrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(i)),
      .wr_en     (add_ok && (cnt_r == CNT_W'(i))),
      .wr_entry  (new_entry),
      .active    (CNT_W'(i) < cnt_r),
      .last      (cnt_r == CNT_W'(i + 1)),
      .tok_v_in  (tok_v[i]),
      .tok_in    (tok[i]),
      .tok_v_out (tok_v[i+1]),
      .tok_out   (tok[i+1])
    );
  end

  // result of this cycle: direct for add, empty or full, else from the row
  always_comb begin
    res_v = 1'b0;
    res   = '{status: ST_EMPTY, idx: '0, entry: '0};
    if (in_fire && is_add) begin
      res_v = 1'b1;
      if (full) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_ADDED;
        res.idx    = idx_low3(cnt_r[IDX_W-1:0]);
        res.entry  = new_entry;
      end
    end else if (in_fire && empty) begin
      res_v = 1'b1;
    end else if (tok_v[MAX_ROUTES]) begin
      res_v      = 1'b1;
      res.status = tok[MAX_ROUTES].status;
      res.idx    = idx_low3(tok[MAX_ROUTES].idx);
      res.entry  = tok[MAX_ROUTES].entry;
    end
  end

  // control state: entry count, busy, pending slot and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (add_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end
      priority if (pend_v_r) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          pend_v_r    <= 1'b0;
          busy_r      <= 1'b0;
        end
      end else if (res_v) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
        end else begin
          pend_v_r <= 1'b1;
          busy_r   <= 1'b1;
        end
      end else begin
        if (out_valid_r && !out_stall) begin
          out_valid_r <= 1'b0;
        end
        if (start) begin
          busy_r <= 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pend_v_r) begin
      if (out_free) begin
        out_r <= pend_r;
      end
    end else if (res_v) begin
      if (out_free) begin
        out_r <= res;
      end else begin
        pend_r <= res;
      end
    end
  end

  // output ports
  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_entry_index = out_r.idx;
  assign out_dst         = out_r.entry.dst;
  assign out_gateway     = out_r.entry.gateway;
  assign out_netmask     = out_r.entry.mask;
  assign out_flags       = out_r.entry.flags;
  assign out_metric      = out_r.entry.metric;
  assign out_device      = out_r.entry.device;

  // checks
  `ASSERT_AT(a_tok_resolved, clk, rst_n, tok_v[MAX_ROUTES] |-> tok[MAX_ROUTES].done, "lookup token left the row unresolved")
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_W'(MAX_ROUTES), "entry count above table size")
  `ASSERT_AT(a_pend_busy, clk, rst_n, pend_v_r |-> busy_r, "pending result while input open")
  `ASSERT_NEVER(a_no_overrun, clk, rst_n, tok_v[MAX_ROUTES] && pend_v_r, "row result with pending slot full")

endmodule
